// ===== sv/sawq_pkg.sv =====
// Shared types and constants of the stop-and-wait ARQ sender.
package sawq_pkg;

  typedef enum logic [1:0] {
    EV_SEND     = 2'd0,
    EV_RESEND   = 2'd1,
    EV_COMPLETE = 2'd2,
    EV_FAILED   = 2'd3
  } ev_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_TICK  = 1'b1
  } act_t;

  typedef enum logic {
    CFG_TIMEOUT  = 1'b0,
    CFG_ATTEMPTS = 1'b1
  } cfg_idx_t;

  localparam int          CFG_W        = 8;
  localparam int          IDX_W        = 8;
  localparam int          CNT_IN_W     = 9;
  localparam logic [7:0]  TIMEOUT_RST  = 8'd3;
  localparam logic [7:0]  ATTEMPTS_RST = 8'd5;

  // one request's results: dbl emits resend then failed for the same frame
  typedef struct packed {
    ev_t              ev;
    logic [IDX_W-1:0] idx;
    logic             dbl;
  } bundle_t;

endpackage

// ===== sv/sawq_core.sv =====
// Sequencer state, configuration registers and per-request result logic.
module sawq_core #(
  parameter int MAX_FRAMES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  sawq_pkg::cfg_idx_t              cfg_index,
  input  logic [sawq_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            acc,
  input  sawq_pkg::act_t                  action,
  input  logic [sawq_pkg::CNT_IN_W-1:0]   frame_count,
  input  logic                            ack_seen,
  output logic                            push,
  output sawq_pkg::bundle_t               bundle
);

  localparam int CW = $clog2(MAX_FRAMES + 1);

  logic [7:0]    timeout_r, attempts_r;
  logic          busy_r, busy_nxt;
  logic [CW-1:0] cur_r, cur_nxt, total_r, total_nxt;
  logic [7:0]    cd_r, cd_nxt, fail_r, fail_nxt;

  logic [CW-1:0] count_c, cur_inc;
  logic [7:0]    fail_inc, limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= sawq_pkg::TIMEOUT_RST;
      attempts_r <= sawq_pkg::ATTEMPTS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sawq_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_wdata;
        sawq_pkg::CFG_ATTEMPTS: attempts_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign count_c  = (int'(frame_count) > MAX_FRAMES) ? CW'(MAX_FRAMES) : CW'(frame_count);
  assign cur_inc  = cur_r + CW'(1);
  assign fail_inc = fail_r + 8'd1;
  assign limit    = (attempts_r == 8'd0) ? 8'd1 : attempts_r;

  always_comb begin
    busy_nxt   = busy_r;
    cur_nxt    = cur_r;
    total_nxt  = total_r;
    cd_nxt     = cd_r;
    fail_nxt   = fail_r;
    push       = 1'b0;
    bundle.ev  = sawq_pkg::EV_SEND;
    bundle.idx = 8'(cur_r);
    bundle.dbl = 1'b0;
    if (acc) begin
      case (action)
        sawq_pkg::ACT_START: begin
          if (!busy_r) begin
            cur_nxt    = '0;
            total_nxt  = count_c;
            fail_nxt   = '0;
            cd_nxt     = timeout_r;
            push       = 1'b1;
            bundle.idx = '0;
            if (count_c == '0) begin
              bundle.ev = sawq_pkg::EV_COMPLETE;
            end else begin
              busy_nxt  = 1'b1;
              bundle.ev = sawq_pkg::EV_SEND;
            end
          end
        end
        sawq_pkg::ACT_TICK: begin
          if (busy_r) begin
            if (ack_seen) begin
              fail_nxt = '0;
              cd_nxt   = timeout_r;
              cur_nxt  = cur_inc;
              push     = 1'b1;
              if (cur_inc >= total_r) begin
                busy_nxt   = 1'b0;
                bundle.ev  = sawq_pkg::EV_COMPLETE;
                bundle.idx = 8'(cur_r);
              end else begin
                bundle.ev  = sawq_pkg::EV_SEND;
                bundle.idx = 8'(cur_inc);
              end
            end else if (cd_r > 8'd1) begin
              cd_nxt = cd_r - 8'd1;
            end else begin
              cd_nxt    = timeout_r;
              fail_nxt  = fail_inc;
              push      = 1'b1;
              bundle.ev = sawq_pkg::EV_RESEND;
              if (fail_inc >= limit) begin
                busy_nxt   = 1'b0;
                bundle.dbl = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cur_r   <= '0;
      total_r <= '0;
      cd_r    <= '0;
      fail_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      cur_r   <= cur_nxt;
      total_r <= total_nxt;
      cd_r    <= cd_nxt;
      fail_r  <= fail_nxt;
    end
  end

  a_busy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_r < total_r))
    else $error("current frame beyond frame total while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && action == sawq_pkg::ACT_START && !busy_r && frame_count != '0) |=> busy_r)
    else $error("start with frames did not enter busy");

endmodule

// ===== sv/sawq_outq.sv =====
// Two-entry result queue with expansion of double results onto the output channel.
module sawq_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  sawq_pkg::bundle_t             bundle,
  output logic                          space,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sawq_pkg::ev_t                 out_event_res,
  output logic [sawq_pkg::IDX_W-1:0]    out_frame_index,
  output logic                          out_last
);

  sawq_pkg::bundle_t q_r [2];
  logic              wr_ptr_r, rd_ptr_r, phase_r;
  logic [1:0]        cnt_r;
  sawq_pkg::bundle_t head;
  logic              hs, pop;

  assign head      = q_r[rd_ptr_r];
  assign space     = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign hs        = out_valid && out_ready;
  assign pop       = hs && (!head.dbl || phase_r);

  assign out_frame_index = head.idx;
  assign out_last        = !head.dbl || phase_r;
  assign out_event_res   = !head.dbl ? head.ev
                         : (phase_r ? sawq_pkg::EV_FAILED : sawq_pkg::EV_RESEND);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      phase_r  <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
      if (hs) phase_r <= head.dbl && !phase_r;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue overflow");

  a_phase_dbl: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (out_valid && head.dbl))
    else $error("second phase without a pending double result");

  a_dbl_second: assert property (@(posedge clk) disable iff (!rst_n)
    (hs && head.dbl && !phase_r) |=> (phase_r && out_valid))
    else $error("double result lost its second half");

endmodule

// ===== sv/stop_and_wait_arq_sender.sv =====
// Top level of the stop-and-wait ARQ sender sequencer.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_action, in_frame_count, in_ack_seen
//   out_     output     out_valid / out_ready out_event_res, out_frame_index, out_last
//   cfg_     input      cfg_wr_en             cfg_index, cfg_wdata
//
// One request per cycle while in_ready is high: state is computed in the acceptance cycle
// and registered; its results enter a two-entry queue, and a resend with failure
// leaves it as resend then failed. in_ready falls only while the queue is full.
// Reset (synchronous, rst_n low) idles the sequencer, empties the queue and loads
// timeout 3 and attempt limit 5.
module stop_and_wait_arq_sender #(
  parameter int MAX_FRAMES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [sawq_pkg::CNT_IN_W-1:0] in_frame_count,
  input  logic                          in_ack_seen,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_event_res,
  output logic [sawq_pkg::IDX_W-1:0]    out_frame_index,
  output logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [sawq_pkg::CFG_W-1:0]    cfg_wdata
);

  logic              acc, push;
  sawq_pkg::bundle_t bundle;
  sawq_pkg::ev_t     ev;

  assign acc           = in_valid && in_ready;
  assign out_event_res = ev;

  sawq_core #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (sawq_pkg::cfg_idx_t'(cfg_index)),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .action      (sawq_pkg::act_t'(in_action)),
    .frame_count (in_frame_count),
    .ack_seen    (in_ack_seen),
    .push        (push),
    .bundle      (bundle)
  );

  sawq_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .bundle          (bundle),
    .space           (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_res   (ev),
    .out_frame_index (out_frame_index),
    .out_last        (out_last)
  );

endmodule
